/* rtl/core/ttip_pkg.sv */
package ttip_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int VALUE_WIDTH = 64;
   localparam int BASE_WIDTH  = 6;
   localparam int CHAR_WIDTH  = 8;
   localparam int OUT_COUNT_WIDTH = 16;

   localparam logic [BASE_WIDTH-1:0] MAX_RADIX = 6'd36;
   localparam logic [BASE_WIDTH-1:0] HEX_RADIX = 6'd16;
   localparam logic [BASE_WIDTH-1:0] DEC_RADIX = 6'd10;
   localparam logic [BASE_WIDTH-1:0] OCT_RADIX = 6'd8;
   localparam logic [BASE_WIDTH-1:0] NO_DIGIT  = 6'd63;

   localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_LOW_X = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CH_UP_X  = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_DIGITS = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_BAD_BASE  = 2'd3;

   localparam logic CSR_NUMBER_BASE   = 1'b0;
   localparam logic CSR_SIGNED_RESULT = 1'b1;

   localparam logic [VALUE_WIDTH-1:0] SIGNED_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] SIGNED_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef enum logic [5:0] {
      PH_DONE   = 6'b000001,
      PH_LEAD   = 6'b000010,
      PH_BODY   = 6'b000100,
      PH_ZERO   = 6'b001000,
      PH_XSEEN  = 6'b010000,
      PH_DIGITS = 6'b100000
   } phase_type;

   function automatic logic [BASE_WIDTH-1:0] digit_value(input logic [CHAR_WIDTH-1:0] c);
      logic [CHAR_WIDTH-1:0] d;
      d = CHAR_WIDTH'(NO_DIGIT);
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30;
      end else if (c inside {[8'h61:8'h7A]}) begin
         d = c - 8'h57;
      end else if (c inside {[8'h41:8'h5A]}) begin
         d = c - 8'h37;
      end
      return d[BASE_WIDTH-1:0];
   endfunction

   function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
      return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
   endfunction

endpackage

/* rtl/core/text_to_integer_parser.sv */
// Streaming text-to-integer converter with strtol / strtoul behavior, 64-bit.
// Input channel req_*: one byte of text per word in req_tdata; req_tuser marks
// the first byte of a new conversion. Leading whitespace and one sign are
// skipped, base 0 detects 0x / 0 prefixes, digits accumulate per byte.
// Result channel rsp_*: one word per conversion, issued on the byte that ends
// the number (the first non-digit, or the start byte itself for a bad base).
// Bytes that arrive with no conversion open give no result.
// Config port csr_*: index 0 is number_base (reset 10), index 1 signed_result
// (reset 1); write only while the block is idle. The base is captured on a
// start byte.
// Throughput is one byte per cycle while req_tready is high; the multiply-add
// of the running value by the radix and its carry-out check are combinational.
// rsp_tvalid rises in the cycle after the terminating byte is accepted.
// When rsp_tready is low the result register holds its word; req_tready stays
// high as long as the result register is empty or being drained this cycle.
// Synchronous reset clears the result valid flag and the parse state; the block
// then ignores bytes until one arrives with req_tuser set.
module text_to_integer_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_char
   input  logic        req_tuser,   // [0] string_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [63:0] result_value, [65:64] result_status,
                                    // [81:66] chars_consumed, [87:82] zero
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);

   localparam int VW = ttip_pkg::VALUE_WIDTH;
   localparam int BW = ttip_pkg::BASE_WIDTH;
   localparam int CW = ttip_pkg::COUNT_WIDTH;
   localparam int OW = ttip_pkg::OUT_COUNT_WIDTH;

   logic [BW-1:0] cfg_base_ff;
   logic          cfg_signed_ff;

   ttip_pkg::phase_type phase_ff, phase_in, c_phase;
   logic [VW-1:0] mag_ff, mag_in, c_mag;
   logic          neg_ff, neg_in, c_neg;
   logic          ovf_ff, ovf_in, c_ovf;
   logic          dig_ff, dig_in, c_dig;
   logic [BW-1:0] base_ff, base_in, c_base;
   logic [CW-1:0] pos_ff, pos_in, c_pos;
   logic [CW-1:0] zpos_ff, zpos_in, c_zpos;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff;
   logic [1:0]    rsp_status_ff;
   logic [OW-1:0] rsp_count_ff;

   logic          accept, start, base_bad;
   logic [7:0]    ch;
   logic [BW-1:0] digit, mac_base;
   logic [VW-1:0] mac_mag;
   logic          mac_ovf;
   logic [CW-1:0] pos_bump, fin_pos;
   logic [VW-1:0] fin_value, emit_value;
   logic [1:0]    fin_status, emit_status;
   logic [OW-1:0] fin_count, emit_count;
   logic          do_digit, do_finish, emit;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign start      = req_tuser;
   assign ch         = req_tdata;
   assign digit      = ttip_pkg::digit_value(ch);
   assign base_bad   = (cfg_base_ff == BW'(1)) || (cfg_base_ff > ttip_pkg::MAX_RADIX);

   assign c_phase = start ? ttip_pkg::PH_LEAD : phase_ff;
   assign c_mag   = start ? '0 : mag_ff;
   assign c_neg   = start ? 1'b0 : neg_ff;
   assign c_ovf   = start ? 1'b0 : ovf_ff;
   assign c_dig   = start ? 1'b0 : dig_ff;
   assign c_base  = start ? cfg_base_ff : base_ff;
   assign c_pos   = start ? '0 : pos_ff;
   assign c_zpos  = start ? '0 : zpos_ff;

   assign pos_bump = (c_pos != {CW{1'b1}}) ? c_pos + CW'(1) : c_pos;

   always_comb begin
      case (c_phase)
         ttip_pkg::PH_LEAD,
         ttip_pkg::PH_BODY:  mac_base = (c_base == '0) ? ttip_pkg::DEC_RADIX : c_base;
         ttip_pkg::PH_ZERO:  mac_base = (c_base == '0) ? ttip_pkg::OCT_RADIX : c_base;
         ttip_pkg::PH_XSEEN: mac_base = ttip_pkg::HEX_RADIX;
         default:            mac_base = c_base;
      endcase
   end

   ttip_mac u_mac (
      .magnitude      (c_mag),
      .base           (mac_base),
      .digit          (digit),
      .next_magnitude (mac_mag),
      .overflow       (mac_ovf)
   );

   always_comb begin
      fin_pos    = (c_phase == ttip_pkg::PH_XSEEN) ? c_zpos : c_pos;
      fin_count  = OW'(fin_pos);
      fin_value  = c_neg ? (VW'(0) - c_mag) : c_mag;
      fin_status = ttip_pkg::ST_OK;
      if (!c_dig) begin
         fin_value  = '0;
         fin_status = ttip_pkg::ST_NO_DIGITS;
         fin_count  = '0;
      end else if (cfg_signed_ff) begin
         if (c_ovf || (!c_neg && c_mag[VW-1]) ||
             (c_neg && c_mag[VW-1] && (|c_mag[VW-2:0]))) begin
            fin_value  = c_neg ? ttip_pkg::SIGNED_MIN : ttip_pkg::SIGNED_MAX;
            fin_status = ttip_pkg::ST_RANGE;
         end
      end else if (c_ovf) begin
         fin_value  = {VW{1'b1}};
         fin_status = ttip_pkg::ST_RANGE;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      ovf_in      = ovf_ff;
      dig_in      = dig_ff;
      base_in     = base_ff;
      pos_in      = pos_ff;
      zpos_in     = zpos_ff;
      do_digit    = 1'b0;
      do_finish   = 1'b0;
      emit        = 1'b0;
      emit_value  = fin_value;
      emit_status = fin_status;
      emit_count  = fin_count;
      if (accept) begin
         phase_in = c_phase;
         mag_in   = c_mag;
         neg_in   = c_neg;
         ovf_in   = c_ovf;
         dig_in   = c_dig;
         base_in  = c_base;
         pos_in   = c_pos;
         zpos_in  = c_zpos;
         if (start && base_bad) begin
            phase_in    = ttip_pkg::PH_DONE;
            emit        = 1'b1;
            emit_value  = '0;
            emit_status = ttip_pkg::ST_BAD_BASE;
            emit_count  = '0;
         end else begin
            case (c_phase)
               ttip_pkg::PH_LEAD,
               ttip_pkg::PH_BODY: begin
                  if (c_phase == ttip_pkg::PH_LEAD && ttip_pkg::is_space(ch)) begin
                     pos_in = pos_bump;
                  end else if (c_phase == ttip_pkg::PH_LEAD &&
                               (ch == ttip_pkg::CH_PLUS || ch == ttip_pkg::CH_MINUS)) begin
                     neg_in   = (ch == ttip_pkg::CH_MINUS);
                     pos_in   = pos_bump;
                     phase_in = ttip_pkg::PH_BODY;
                  end else if ((c_base == '0 || c_base == ttip_pkg::HEX_RADIX) &&
                               ch == ttip_pkg::CH_ZERO) begin
                     mag_in   = '0;
                     dig_in   = 1'b1;
                     pos_in   = pos_bump;
                     zpos_in  = pos_bump;
                     phase_in = ttip_pkg::PH_ZERO;
                  end else begin
                     base_in  = mac_base;
                     phase_in = ttip_pkg::PH_DIGITS;
                     do_digit = 1'b1;
                  end
               end
               ttip_pkg::PH_ZERO: begin
                  if (ch == ttip_pkg::CH_LOW_X || ch == ttip_pkg::CH_UP_X) begin
                     pos_in   = pos_bump;
                     phase_in = ttip_pkg::PH_XSEEN;
                  end else begin
                     base_in  = mac_base;
                     phase_in = ttip_pkg::PH_DIGITS;
                     do_digit = 1'b1;
                  end
               end
               ttip_pkg::PH_XSEEN: begin
                  if (digit < ttip_pkg::HEX_RADIX) begin
                     base_in  = ttip_pkg::HEX_RADIX;
                     phase_in = ttip_pkg::PH_DIGITS;
                     do_digit = 1'b1;
                  end else begin
                     pos_in    = c_zpos;
                     do_finish = 1'b1;
                  end
               end
               ttip_pkg::PH_DIGITS: begin
                  do_digit = 1'b1;
               end
               default: begin
               end
            endcase
            if (do_digit) begin
               if (digit >= mac_base) begin
                  do_finish = 1'b1;
               end else begin
                  if (mac_ovf) begin
                     ovf_in = 1'b1;
                  end else begin
                     mag_in = mac_mag;
                  end
                  dig_in = 1'b1;
                  pos_in = pos_bump;
               end
            end
            if (do_finish) begin
               phase_in = ttip_pkg::PH_DONE;
               emit     = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_base_ff   <= ttip_pkg::DEC_RADIX;
         cfg_signed_ff <= 1'b1;
         phase_ff      <= ttip_pkg::PH_DONE;
         mag_ff        <= '0;
         neg_ff        <= 1'b0;
         ovf_ff        <= 1'b0;
         dig_ff        <= 1'b0;
         base_ff       <= ttip_pkg::DEC_RADIX;
         pos_ff        <= '0;
         zpos_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we && csr_index == ttip_pkg::CSR_NUMBER_BASE) begin
            cfg_base_ff <= csr_wdata;
         end
         if (csr_we && csr_index == ttip_pkg::CSR_SIGNED_RESULT) begin
            cfg_signed_ff <= csr_wdata[0];
         end
         phase_ff     <= phase_in;
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         ovf_ff       <= ovf_in;
         dig_ff       <= dig_in;
         base_ff      <= base_in;
         pos_ff       <= pos_in;
         zpos_ff      <= zpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_value_ff  <= emit_value;
         rsp_status_ff <= emit_status;
         rsp_count_ff  <= emit_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_count_ff, rsp_status_ff, rsp_value_ff};

`ifndef ASSERT_OFF
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> rsp_valid_ff)
      else $error("result word not registered");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !start && phase_ff == ttip_pkg::PH_DONE) |-> !emit)
      else $error("result issued with no conversion open");

   a_bad_base_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ttip_pkg::ST_BAD_BASE) |->
         (rsp_value_ff == '0 && rsp_count_ff == '0))
      else $error("bad base result not zero");

   a_no_digit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ttip_pkg::ST_NO_DIGITS) |->
         (rsp_value_ff == '0 && rsp_count_ff == '0))
      else $error("no-digit result not zero");

   a_ovf_has_digit: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> dig_ff)
      else $error("overflow without digits");
`endif

endmodule

/* rtl/core/ttip_mac.sv */
module ttip_mac (
   input  logic [ttip_pkg::VALUE_WIDTH-1:0] magnitude,
   input  logic [ttip_pkg::BASE_WIDTH-1:0]  base,
   input  logic [ttip_pkg::BASE_WIDTH-1:0]  digit,
   output logic [ttip_pkg::VALUE_WIDTH-1:0] next_magnitude,
   output logic                             overflow
);

   localparam int PROD_WIDTH = ttip_pkg::VALUE_WIDTH + ttip_pkg::BASE_WIDTH;

   logic [PROD_WIDTH-1:0] prod;

   assign prod = PROD_WIDTH'(magnitude) * PROD_WIDTH'(base) + PROD_WIDTH'(digit);
   assign next_magnitude = prod[ttip_pkg::VALUE_WIDTH-1:0];
   assign overflow = |prod[PROD_WIDTH-1:ttip_pkg::VALUE_WIDTH];

endmodule

/* bench/text_to_integer_parser_tb.sv */
module text_to_integer_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET     = 1400;
   localparam int QUIET_TAIL      = 150;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  status;
      logic [15:0] count;
   } conversion_type;

   class conversion_scoreboard;
      conversion_type expected_conversions[$];
      int unsigned errors;
      logic [5:0]  base_reg;
      logic        signed_reg;
      ttip_pkg::phase_type phase;
      logic [63:0] magnitude;
      logic        negative;
      logic        overflow;
      logic        any_digit;
      logic [5:0]  radix;
      logic [15:0] position;
      logic [15:0] zero_position;

      function new();
         errors        = 0;
         base_reg      = ttip_pkg::DEC_RADIX;
         signed_reg    = 1'b1;
         phase         = ttip_pkg::PH_DONE;
         magnitude     = '0;
         negative      = 1'b0;
         overflow      = 1'b0;
         any_digit     = 1'b0;
         radix         = ttip_pkg::DEC_RADIX;
         position      = '0;
         zero_position = '0;
      endfunction

      static function int char_digit(logic [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
         if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 10;
         if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41 + 10;
         return 99;
      endfunction

      function int pending();
         return expected_conversions.size();
      endfunction

      function void write_register(logic index, logic [5:0] data);
         if (index == ttip_pkg::CSR_NUMBER_BASE) base_reg = data;
         else signed_reg = data[0];
      endfunction

      function void conclude(logic [63:0] value, logic [1:0] status, logic [15:0] count);
         conversion_type c;
         c.value  = value;
         c.status = status;
         c.count  = count;
         expected_conversions.push_back(c);
         phase = ttip_pkg::PH_DONE;
      endfunction

      function void bump();
         if (position != 16'hFFFF) position++;
      endfunction

      function void finish_number();
         logic [63:0] negated;
         negated = 64'd0 - magnitude;
         if (!any_digit) begin
            conclude(64'd0, ttip_pkg::ST_NO_DIGITS, 16'd0);
         end else if (signed_reg) begin
            if (overflow || (!negative && magnitude > ttip_pkg::SIGNED_MAX) ||
                (negative && magnitude > ttip_pkg::SIGNED_MIN))
               conclude(negative ? ttip_pkg::SIGNED_MIN : ttip_pkg::SIGNED_MAX,
                        ttip_pkg::ST_RANGE, position);
            else
               conclude(negative ? negated : magnitude, ttip_pkg::ST_OK, position);
         end else begin
            if (overflow) conclude({64{1'b1}}, ttip_pkg::ST_RANGE, position);
            else conclude(negative ? negated : magnitude, ttip_pkg::ST_OK, position);
         end
      endfunction

      function void accumulate(logic [7:0] c);
         int d;
         int r;
         logic [69:0] wide;
         d = char_digit(c);
         r = int'(radix);
         if (d >= r) begin
            finish_number();
            return;
         end
         wide = 70'(magnitude) * 70'(radix) + 70'(d);
         if (wide[69:64] != '0) overflow = 1'b1;
         else magnitude = wide[63:0];
         any_digit = 1'b1;
         bump();
      endfunction

      function void take_body(logic [7:0] c);
         if ((radix == 6'd0 || radix == ttip_pkg::HEX_RADIX) && c == ttip_pkg::CH_ZERO) begin
            magnitude     = '0;
            any_digit     = 1'b1;
            bump();
            zero_position = position;
            phase         = ttip_pkg::PH_ZERO;
            return;
         end
         if (radix == 6'd0) radix = ttip_pkg::DEC_RADIX;
         phase = ttip_pkg::PH_DIGITS;
         accumulate(c);
      endfunction

      function void note_word(logic [7:0] c, logic start);
         if (start) begin
            magnitude     = '0;
            negative      = 1'b0;
            overflow      = 1'b0;
            any_digit     = 1'b0;
            position      = '0;
            zero_position = '0;
            radix         = base_reg;
            if (radix == 6'd1 || radix > ttip_pkg::MAX_RADIX) begin
               conclude(64'd0, ttip_pkg::ST_BAD_BASE, 16'd0);
               return;
            end
            phase = ttip_pkg::PH_LEAD;
         end
         case (phase)
            ttip_pkg::PH_LEAD: begin
               if (c == ttip_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
                  bump();
               end else if (c == ttip_pkg::CH_PLUS || c == ttip_pkg::CH_MINUS) begin
                  negative = (c == ttip_pkg::CH_MINUS);
                  bump();
                  phase = ttip_pkg::PH_BODY;
               end else begin
                  take_body(c);
               end
            end
            ttip_pkg::PH_BODY: take_body(c);
            ttip_pkg::PH_ZERO: begin
               if (c == ttip_pkg::CH_LOW_X || c == ttip_pkg::CH_UP_X) begin
                  bump();
                  phase = ttip_pkg::PH_XSEEN;
               end else begin
                  if (radix == 6'd0) radix = ttip_pkg::OCT_RADIX;
                  phase = ttip_pkg::PH_DIGITS;
                  accumulate(c);
               end
            end
            ttip_pkg::PH_XSEEN: begin
               if (char_digit(c) < 16) begin
                  radix = ttip_pkg::HEX_RADIX;
                  phase = ttip_pkg::PH_DIGITS;
                  accumulate(c);
               end else begin
                  position = zero_position;
                  finish_number();
               end
            end
            ttip_pkg::PH_DIGITS: accumulate(c);
            default: ;
         endcase
      endfunction

      task report_mismatch(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_word(input logic [87:0] word);
         conversion_type want;
         if (expected_conversions.size() == 0) begin
            report_mismatch($sformatf("unexpected result word %h", word));
            return;
         end
         want = expected_conversions.pop_front();
         if (word[63:0] != want.value)
            report_mismatch($sformatf("value got %h want %h", word[63:0], want.value));
         if (word[65:64] != want.status)
            report_mismatch($sformatf("status got %0d want %0d", word[65:64], want.status));
         if (word[81:66] != want.count)
            report_mismatch($sformatf("count got %0d want %0d", word[81:66], want.count));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic [5:0]  csr_wdata  = 6'd0;

   conversion_scoreboard sb;
   logic [5:0] cur_base;
   bit         idle_enabled     = 1'b0;
   bit         hold_off_request = 1'b0;
   int         words_sent       = 0;
   string      decimal_limits[4] = '{"9223372036854775807", "9223372036854775808",
                                     "18446744073709551615", "18446744073709551616"};

   text_to_integer_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_word(req_tdata, req_tuser);
         if (csr_we) sb.write_register(csr_index, csr_wdata);
      end
   end

   initial begin : receiver
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] digit_char(int v);
      if (v < 10) return 8'(v + 'h30);
      return 8'(v - 10 + ($urandom_range(0, 1) ? 'h61 : 'h41));
   endfunction

   function automatic int wrap_digits(int r);
      logic [127:0] v;
      int n;
      v = 128'd1;
      n = 0;
      while (v < (128'd1 << 64)) begin
         v = v * r;
         n++;
      end
      return n;
   endfunction

   task automatic send_word(input logic [7:0] c, input logic start);
      if (words_sent >= ITEM_TARGET - QUIET_TAIL) idle_enabled = 1'b0;
      if (idle_enabled && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_text(input string s, input logic start);
      for (int i = 0; i < s.len(); i++) send_word(s[i], start && i == 0);
   endtask

   task automatic wait_for_drain();
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_config(input logic [5:0] base, input logic sgn);
      send_word(8'h00, 1'b0);
      req_tvalid <= 1'b0;
      wait_for_drain();
      csr_we    <= 1'b1;
      csr_index <= ttip_pkg::CSR_NUMBER_BASE;
      csr_wdata <= base;
      @(negedge clock);
      csr_index <= ttip_pkg::CSR_SIGNED_RESULT;
      csr_wdata <= {5'd0, sgn};
      @(negedge clock);
      csr_we     <= 1'b0;
      cur_base   = base;
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6))
         send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
   endtask

   task automatic send_number_string();
      logic [7:0] text[$];
      logic [7:0] stop;
      string      limit_text;
      int         r;
      int         len;
      int         mode;
      r = (cur_base == 6'd1 || cur_base > ttip_pkg::MAX_RADIX) ? 10 : int'(cur_base);
      repeat ($urandom_range(0, 2))
         text.push_back($urandom_range(0, 1) ? ttip_pkg::CH_SPACE
                                             : 8'($urandom_range(9, 13)));
      case ($urandom_range(0, 3))
         1: text.push_back(ttip_pkg::CH_PLUS);
         2: text.push_back(ttip_pkg::CH_MINUS);
         default: ;
      endcase
      if (cur_base == 6'd0) begin
         case ($urandom_range(0, 2))
            0: begin
               text.push_back(ttip_pkg::CH_ZERO);
               text.push_back($urandom_range(0, 1) ? ttip_pkg::CH_LOW_X : ttip_pkg::CH_UP_X);
               r = 16;
            end
            1: begin
               text.push_back(ttip_pkg::CH_ZERO);
               r = 8;
            end
            default: r = 10;
         endcase
      end else if (cur_base == ttip_pkg::HEX_RADIX && $urandom_range(0, 2) == 0) begin
         text.push_back(ttip_pkg::CH_ZERO);
         text.push_back($urandom_range(0, 1) ? ttip_pkg::CH_LOW_X : ttip_pkg::CH_UP_X);
      end
      mode = $urandom_range(0, 9);
      if (mode == 8 && r == 10 && $urandom_range(0, 1)) begin
         limit_text = decimal_limits[$urandom_range(0, 3)];
         for (int i = 0; i < limit_text.len(); i++) text.push_back(limit_text[i]);
      end else begin
         if (mode < 6) len = $urandom_range(0, 5);
         else if (mode < 8) len = $urandom_range(6, 24);
         else if (mode == 8) len = wrap_digits(r) + $urandom_range(0, 2);
         else len = wrap_digits(r) - 1 + $urandom_range(0, 2);
         for (int i = 0; i < len; i++) begin
            if (mode == 8) text.push_back(digit_char(i == 0 ? 1 : 0));
            else if (mode == 9) text.push_back(digit_char(r - 1));
            else text.push_back(digit_char($urandom_range(0, r - 1)));
         end
      end
      if ($urandom_range(0, 9) != 0 || text.size() == 0) begin
         do begin
            case ($urandom_range(0, 3))
               0: stop = 8'h00;
               1: stop = ttip_pkg::CH_SPACE;
               2: stop = 8'($urandom_range(0, 255));
               default: stop = digit_char($urandom_range(r < 36 ? r : 0, 35));
            endcase
         end while (conversion_scoreboard::char_digit(stop) < r);
         text.push_back(stop);
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
      end
      for (int i = 0; i < text.size(); i++) send_word(text[i], i == 0);
   endtask

   initial begin : stimulus
      logic [5:0] plan_base [11];
      logic       plan_signed [11];
      logic [5:0] base;
      logic       sgn;
      int         phase_idx;
      int         phase_start;
      int         phase_quota;
      int         drain_cycles;
      plan_base   = '{ttip_pkg::DEC_RADIX, 6'd0, ttip_pkg::HEX_RADIX, 6'd2,
                      ttip_pkg::MAX_RADIX, ttip_pkg::OCT_RADIX,
                      6'd0, 6'd1, 6'd37, 6'd63, ttip_pkg::DEC_RADIX};
      plan_signed = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      sb         = new();
      cur_base   = ttip_pkg::DEC_RADIX;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      send_word(8'h41, 1'b0);
      send_text("\t-7", 1'b1);
      send_word(8'h00, 1'b0);
      send_text("+,", 1'b1);
      send_word(8'hFF, 1'b1);
      send_word(8'h80, 1'b0);
      send_text("12", 1'b1);
      send_text("3 ", 1'b1);
      apply_config(6'd0, 1'b0);
      send_text("0x1g", 1'b1);
      send_text("0Xg", 1'b1);
      send_text("017 ", 1'b1);
      send_text("-1.", 1'b1);
      apply_config(6'd1, 1'b1);
      send_text("5", 1'b1);
      apply_config(ttip_pkg::MAX_RADIX, 1'b1);
      send_text("zZ.", 1'b1);

      phase_idx = 0;
      while (words_sent < ITEM_TARGET) begin
         if (phase_idx < 11) begin
            base = plan_base[phase_idx];
            sgn  = plan_signed[phase_idx];
         end else begin
            base = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(37, 63))
                                               : 6'($urandom_range(0, 36));
            sgn  = $urandom_range(0, 1);
         end
         apply_config(base, sgn);
         idle_enabled = (words_sent < ITEM_TARGET - QUIET_TAIL) &&
                        ($urandom_range(0, 3) != 0);
         if (phase_idx == 2) hold_off_request = 1'b1;
         phase_start = words_sent;
         phase_quota = (base == 6'd1 || base > ttip_pkg::MAX_RADIX) ? 30
                                                                   : $urandom_range(80, 140);
         while (words_sent - phase_start < phase_quota) begin
            if ($urandom_range(0, 5) == 0) send_noise();
            else send_number_string();
         end
         phase_idx++;
      end

      send_word(8'h00, 1'b0);
      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (sb.pending() != 0 && drain_cycles < 5000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (8) @(negedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
